// ===== hw/rtl/csim_pkg.sv =====
// Shared types and constants for the streaming cosine similarity block.
// Used by csim_alu and cosine_similarity_stream; depends on nothing.
`timescale 1ns / 1ps

package csim_pkg;

  localparam int WEIGHT_W = 16;
  localparam int DOT_W    = 44;
  localparam int NORM_W   = 43;
  localparam int MUL_W    = 33;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int WIDE_W   = 64;
  localparam int ROOT_W   = 32;
  localparam int DEN_W    = 63;
  localparam int QUO_W    = 16;
  localparam int CNT_W    = 5;

  localparam logic [CNT_W-1:0] SQRT_STEPS_M1 = CNT_W'(ROOT_W - 1);
  localparam logic [CNT_W-1:0] DIV_STEPS_M1  = CNT_W'(QUO_W - 1);
  localparam int NORM_SHIFT = 20;
  localparam int DIV_SHIFT  = 19;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] user_weight;
    logic signed [WEIGHT_W-1:0] doc_weight;
    logic                       is_last;
  } item_t;

  typedef struct packed {
    logic signed [QUO_W-1:0] similarity;
    logic                    zero_norm;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_UD,
    S_MUL_UU,
    S_MUL_DD,
    S_ACC_DD,
    S_CHECK,
    S_SQRT_U,
    S_SQRT_D,
    S_MUL_DEN,
    S_DEN,
    S_DIV_CHK,
    S_DIV,
    S_OUT
  } state_t;

endpackage

// ===== hw/rtl/cosine_similarity_stream.sv =====
// Streaming cosine similarity: accumulates dot product and both norms, one term per transfer.
// Each non-last term runs three multiplies in turn; item_stall holds until the sequencer is idle again.
// A last term then runs two 32-step square roots and a 16-step division (skipped when the
// quotient saturates) on one shared multiplier and compare-subtract unit; a zero norm skips to the output.
// Synchronous active-high reset clears the sequencer, accumulators and result valid.
`timescale 1ns / 1ps

module cosine_similarity_stream (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  csim_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output csim_pkg::result_t result
);

  csim_pkg::state_t state, state_next;

  csim_pkg::item_t                         item_q;
  logic signed [csim_pkg::DOT_W-1:0]       dot_sum;
  logic        [csim_pkg::NORM_W-1:0]      user_norm_sum;
  logic        [csim_pkg::NORM_W-1:0]      doc_norm_sum;
  logic        [csim_pkg::WIDE_W-1:0]      sq_v;
  logic        [csim_pkg::WIDE_W-1:0]      sq_res;
  logic        [csim_pkg::WIDE_W-1:0]      sq_bit;
  logic        [csim_pkg::ROOT_W-1:0]      su;
  logic        [csim_pkg::ROOT_W-1:0]      sd;
  logic        [csim_pkg::DEN_W-1:0]       den;
  logic        [csim_pkg::WIDE_W-1:0]      rem;
  logic        [csim_pkg::QUO_W-1:0]       quo;
  logic                                    sat;
  logic                                    zero_flag;
  logic        [csim_pkg::CNT_W-1:0]       cnt;

  logic signed [csim_pkg::MUL_W-1:0]       mul_a, mul_b;
  logic signed [csim_pkg::PROD_W-1:0]      prod;
  logic        [csim_pkg::WIDE_W-1:0]      sub_a, sub_b, diff;
  logic                                    ge;
  logic                                    accept, load;

  logic        [csim_pkg::DOT_W:0]         dot_add;
  logic        [csim_pkg::DOT_W-1:0]       dot_next;
  logic        [csim_pkg::NORM_W:0]        unorm_add, dnorm_add;
  logic        [csim_pkg::NORM_W-1:0]      unorm_next, dnorm_next;
  logic        [csim_pkg::DOT_W-1:0]       mag;
  logic        [csim_pkg::WIDE_W-1:0]      sq_res_next;
  logic signed [csim_pkg::QUO_W-1:0]       sim;

  csim_alu u_alu (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .prod  (prod),
    .sub_a (sub_a),
    .sub_b (sub_b),
    .ge    (ge),
    .diff  (diff)
  );

  assign item_stall = (state != csim_pkg::S_IDLE);
  assign accept     = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csim_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load       = 1'b0;
    case (state)
      csim_pkg::S_IDLE:    if (item_valid) state_next = csim_pkg::S_MUL_UD;
      csim_pkg::S_MUL_UD:  state_next = csim_pkg::S_MUL_UU;
      csim_pkg::S_MUL_UU:  state_next = csim_pkg::S_MUL_DD;
      csim_pkg::S_MUL_DD:  state_next = csim_pkg::S_ACC_DD;
      csim_pkg::S_ACC_DD:  state_next = item_q.is_last ? csim_pkg::S_CHECK : csim_pkg::S_IDLE;
      csim_pkg::S_CHECK: begin
        if (user_norm_sum == '0 || doc_norm_sum == '0) begin
          state_next = csim_pkg::S_OUT;
        end else begin
          state_next = csim_pkg::S_SQRT_U;
        end
      end
      csim_pkg::S_SQRT_U:  if (cnt == '0) state_next = csim_pkg::S_SQRT_D;
      csim_pkg::S_SQRT_D:  if (cnt == '0) state_next = csim_pkg::S_MUL_DEN;
      csim_pkg::S_MUL_DEN: state_next = csim_pkg::S_DEN;
      csim_pkg::S_DEN:     state_next = csim_pkg::S_DIV_CHK;
      csim_pkg::S_DIV_CHK: state_next = ge ? csim_pkg::S_OUT : csim_pkg::S_DIV;
      csim_pkg::S_DIV:     if (cnt == '0) state_next = csim_pkg::S_OUT;
      csim_pkg::S_OUT: begin
        if (!result_valid || !result_stall) begin
          load       = 1'b1;
          state_next = csim_pkg::S_IDLE;
        end
      end
      default:             state_next = csim_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    sub_a = '0;
    sub_b = '0;
    case (state)
      csim_pkg::S_MUL_UD: begin
        mul_a = csim_pkg::MUL_W'(item_q.user_weight);
        mul_b = csim_pkg::MUL_W'(item_q.doc_weight);
      end
      csim_pkg::S_MUL_UU: begin
        mul_a = csim_pkg::MUL_W'(item_q.user_weight);
        mul_b = csim_pkg::MUL_W'(item_q.user_weight);
      end
      csim_pkg::S_MUL_DD: begin
        mul_a = csim_pkg::MUL_W'(item_q.doc_weight);
        mul_b = csim_pkg::MUL_W'(item_q.doc_weight);
      end
      csim_pkg::S_MUL_DEN: begin
        mul_a = $signed({1'b0, su});
        mul_b = $signed({1'b0, sd});
      end
      csim_pkg::S_SQRT_U, csim_pkg::S_SQRT_D: begin
        sub_a = sq_v;
        sub_b = sq_res + sq_bit;
      end
      csim_pkg::S_DIV_CHK: begin
        sub_a = rem;
        sub_b = {1'b0, den};
      end
      csim_pkg::S_DIV: begin
        sub_a = {rem[csim_pkg::WIDE_W-2:0], 1'b0};
        sub_b = {1'b0, den};
      end
      default: begin
        sub_a = '0;
      end
    endcase
  end

  assign dot_add = {dot_sum[csim_pkg::DOT_W-1], dot_sum}
                 + {{(csim_pkg::DOT_W-31){prod[31]}}, prod[31:0]};
  assign dot_next = (dot_add[csim_pkg::DOT_W] != dot_add[csim_pkg::DOT_W-1])
                  ? {dot_add[csim_pkg::DOT_W], {(csim_pkg::DOT_W-1){~dot_add[csim_pkg::DOT_W]}}}
                  : dot_add[csim_pkg::DOT_W-1:0];

  assign unorm_add  = {1'b0, user_norm_sum} + {(csim_pkg::NORM_W-31)'(0), prod[31:0]};
  assign dnorm_add  = {1'b0, doc_norm_sum} + {(csim_pkg::NORM_W-31)'(0), prod[31:0]};
  assign unorm_next = unorm_add[csim_pkg::NORM_W] ? '1 : unorm_add[csim_pkg::NORM_W-1:0];
  assign dnorm_next = dnorm_add[csim_pkg::NORM_W] ? '1 : dnorm_add[csim_pkg::NORM_W-1:0];

  assign mag = dot_sum[csim_pkg::DOT_W-1] ? (~dot_sum + 1'b1) : dot_sum;

  assign sq_res_next = ge ? ((sq_res >> 1) + sq_bit) : (sq_res >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_sum       <= '0;
      user_norm_sum <= '0;
      doc_norm_sum  <= '0;
    end else begin
      case (state)
        csim_pkg::S_MUL_UU: dot_sum       <= dot_next;
        csim_pkg::S_MUL_DD: user_norm_sum <= unorm_next;
        csim_pkg::S_ACC_DD: doc_norm_sum  <= dnorm_next;
        csim_pkg::S_OUT: begin
          if (load) begin
            dot_sum       <= '0;
            user_norm_sum <= '0;
            doc_norm_sum  <= '0;
          end
        end
        default: dot_sum <= dot_sum;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
    case (state)
      csim_pkg::S_CHECK: begin
        zero_flag <= (user_norm_sum == '0) || (doc_norm_sum == '0);
        sat       <= 1'b0;
        quo       <= '0;
        sq_v      <= {(csim_pkg::WIDE_W-csim_pkg::NORM_W-csim_pkg::NORM_SHIFT)'(0),
                      user_norm_sum, csim_pkg::NORM_SHIFT'(0)};
        sq_res    <= '0;
        sq_bit    <= {2'b01, (csim_pkg::WIDE_W-2)'(0)};
        cnt       <= csim_pkg::SQRT_STEPS_M1;
      end
      csim_pkg::S_SQRT_U: begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          su     <= sq_res_next[csim_pkg::ROOT_W-1:0];
          sq_v   <= {(csim_pkg::WIDE_W-csim_pkg::NORM_W-csim_pkg::NORM_SHIFT)'(0),
                     doc_norm_sum, csim_pkg::NORM_SHIFT'(0)};
          sq_res <= '0;
          sq_bit <= {2'b01, (csim_pkg::WIDE_W-2)'(0)};
          cnt    <= csim_pkg::SQRT_STEPS_M1;
        end else begin
          if (ge) sq_v <= diff;
          sq_res <= sq_res_next;
          sq_bit <= sq_bit >> 2;
        end
      end
      csim_pkg::S_SQRT_D: begin
        cnt    <= cnt - 1'b1;
        sq_res <= sq_res_next;
        sq_bit <= sq_bit >> 2;
        if (ge) sq_v <= diff;
        if (cnt == '0) begin
          sd <= sq_res_next[csim_pkg::ROOT_W-1:0];
        end
      end
      csim_pkg::S_DEN: begin
        den <= prod[csim_pkg::DEN_W-1:0];
        rem <= {1'b0, mag, csim_pkg::DIV_SHIFT'(0)};
      end
      csim_pkg::S_DIV_CHK: begin
        sat <= ge;
        cnt <= csim_pkg::DIV_STEPS_M1;
      end
      csim_pkg::S_DIV: begin
        cnt <= cnt - 1'b1;
        rem <= ge ? diff : {rem[csim_pkg::WIDE_W-2:0], 1'b0};
        quo <= {quo[csim_pkg::QUO_W-2:0], ge};
      end
      default: begin
        cnt <= cnt;
      end
    endcase
  end

  always_comb begin
    if (zero_flag) begin
      sim = '0;
    end else if (!dot_sum[csim_pkg::DOT_W-1]) begin
      sim = (sat || quo[csim_pkg::QUO_W-1]) ? {1'b0, {(csim_pkg::QUO_W-1){1'b1}}} : $signed(quo);
    end else if (sat || quo > {1'b1, (csim_pkg::QUO_W-1)'(0)}) begin
      sim = {1'b1, (csim_pkg::QUO_W-1)'(0)};
    end else begin
      sim = $signed(~quo + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.similarity <= sim;
      result.zero_norm  <= zero_flag;
    end
  end

`ifndef SYNTHESIS
  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == csim_pkg::S_OUT)
    else $error("result raised outside the output step");

  a_clear_after_load: assert property (@(posedge clk) disable iff (rst)
    load |=> (dot_sum == '0 && user_norm_sum == '0 && doc_norm_sum == '0))
    else $error("accumulators not cleared after result load");

  a_zero_norm_sim: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.zero_norm) |-> result.similarity == '0)
    else $error("zero norm result carries nonzero similarity");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (state == csim_pkg::S_DIV) |-> (rem < {1'b0, den}))
    else $error("division remainder not below divisor");

  a_sqrt_bit_onehot: assert property (@(posedge clk) disable iff (rst)
    (state == csim_pkg::S_SQRT_U || state == csim_pkg::S_SQRT_D) |-> $onehot(sq_bit))
    else $error("square root trial bit lost");
`endif

endmodule

// ===== hw/rtl/csim_alu.sv =====
// Shared arithmetic unit: one registered signed multiplier and one wide compare-subtract.
// Depends on csim_pkg for widths.
`timescale 1ns / 1ps

module csim_alu (
  input  logic                                     clk,
  input  logic signed [csim_pkg::MUL_W-1:0]        mul_a,
  input  logic signed [csim_pkg::MUL_W-1:0]        mul_b,
  output logic signed [csim_pkg::PROD_W-1:0]       prod,
  input  logic        [csim_pkg::WIDE_W-1:0]       sub_a,
  input  logic        [csim_pkg::WIDE_W-1:0]       sub_b,
  output logic                                     ge,
  output logic        [csim_pkg::WIDE_W-1:0]       diff
);

  logic [csim_pkg::WIDE_W:0] wide_sub;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign wide_sub = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge       = ~wide_sub[csim_pkg::WIDE_W];
  assign diff     = wide_sub[csim_pkg::WIDE_W-1:0];

endmodule
